/* rtl/bgc_pkg.sv */
package bgc_pkg;

  // Number of buttons tracked by the classifier.
  localparam int BUTTONS = 4;
  localparam int BTN_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  // Configuration port geometry: three registers at 4-byte spacing.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POLL    = 2'd2
  } op_t;

  // Result event kinds.
  typedef enum logic [1:0] {
    EV_SINGLE = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } ev_t;

  // Per-button gesture state.
  typedef enum logic [2:0] {
    G_IDLE      = 3'd0,
    G_PRESSED   = 3'd1,
    G_SHORT_REL = 3'd2,
    G_SECOND    = 3'd3,
    G_LONG      = 3'd4
  } gesture_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_DOUBLE   = 2'd2
  } reg_idx_t;

  // Timing settings handed from the register block to the engine.
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] double_window_ms;
  } cfg_t;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  button_index;
    logic [31:0] now_ms;
  } item_t;

endpackage

/* rtl/bgc_if.sv */
// Input channel: one press, release or poll beat.
interface bgc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  button_index;
  logic [31:0] now_ms;

  modport source (output valid, output operation, output button_index, output now_ms,
                  input ready);
  modport sink (input valid, input operation, input button_index, input now_ms,
                output ready);
endinterface

// Result channel: one classified gesture event.
interface bgc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_button;
  logic [1:0] event_kind;

  modport source (output valid, output event_button, output event_kind, input ready);
  modport sink (input valid, input event_button, input event_kind, output ready);
endinterface

/* rtl/bgc_cfg.sv */
module bgc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bgc_pkg::CFG_AW-1:0]   paddr,
  input  logic [bgc_pkg::CFG_DW-1:0]   pwdata,
  output logic [bgc_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output bgc_pkg::cfg_t                cfg
);
  import bgc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  // Register writes; the upper half of the data word is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= 16'd20;
      cfg_r.long_press_ms    <= 16'd1000;
      cfg_r.double_window_ms <= 16'd300;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE: cfg_r.debounce_ms      <= pwdata[15:0];
        REG_LONG:     cfg_r.long_press_ms    <= pwdata[15:0];
        REG_DOUBLE:   cfg_r.double_window_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux; the unmapped slot at 0xC reads as zero.
  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = {16'd0, cfg_r.debounce_ms};
      REG_LONG:     prdata = {16'd0, cfg_r.long_press_ms};
      REG_DOUBLE:   prdata = {16'd0, cfg_r.double_window_ms};
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/bgc_engine.sv */
module bgc_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  bgc_pkg::cfg_t   cfg,
  input  logic            item_valid,
  input  bgc_pkg::item_t  item,
  output logic            item_ready,
  bgc_out_if.source       out_ch
);
  import bgc_pkg::*;

  // Per-button state and stamps.
  gesture_t          state_r   [BUTTONS];
  logic [31:0]       press_r   [BUTTONS];
  logic [31:0]       release_r [BUTTONS];
  logic [31:0]       last_r    [BUTTONS];
  logic [BTN_W-1:0]  ptr_r;

  logic              out_valid_r;
  logic [1:0]        out_button_r;
  ev_t               out_kind_r;

  op_t               op;
  logic              go;
  logic              in_range;
  logic              is_edge;
  logic              edge_ok;
  logic [BTN_W-1:0]  sel;
  gesture_t          st;
  gesture_t          st_nxt;
  logic [31:0]       press_age;
  logic [31:0]       rel_age;
  logic [31:0]       edge_age;
  logic [31:0]       press_nxt;
  logic [31:0]       release_nxt;
  logic              ev_valid;
  ev_t               ev_kind;
  logic [BTN_W-1:0]  ptr_nxt;

  // The item moves on whenever the result register is free or being drained.
  assign item_ready = !out_valid_r || out_ch.ready;
  assign go         = item_valid && item_ready;

  // Operand selection: polls look at the round-robin button, edges at their own.
  assign op       = op_t'(item.operation);
  assign in_range = {30'd0, item.button_index} < 32'(BUTTONS);
  assign is_edge  = (op == OP_PRESS) || (op == OP_RELEASE);
  assign sel      = (op == OP_POLL) ? ptr_r : BTN_W'(item.button_index);
  assign st       = state_r[sel];

  // Wrapping time differences against the stored stamps.
  assign press_age = item.now_ms - press_r[sel];
  assign rel_age   = item.now_ms - release_r[sel];
  assign edge_age  = item.now_ms - last_r[sel];
  assign edge_ok   = is_edge && in_range && (edge_age >= {16'd0, cfg.debounce_ms});

  // Next gesture state of the selected button.
  always_comb begin
    st_nxt = st;
    case (op)
      OP_PRESS: begin
        if (edge_ok) begin
          case (st)
            G_SHORT_REL:        st_nxt = G_SECOND;
            G_PRESSED, G_SECOND: st_nxt = st;
            default:            st_nxt = G_PRESSED;
          endcase
        end
      end
      OP_RELEASE: begin
        if (edge_ok) begin
          case (st)
            G_PRESSED: st_nxt = G_SHORT_REL;
            default:   st_nxt = G_IDLE;
          endcase
        end
      end
      OP_POLL: begin
        case (st)
          G_SHORT_REL: begin
            if (rel_age >= {16'd0, cfg.double_window_ms}) st_nxt = G_IDLE;
          end
          G_PRESSED, G_SECOND: begin
            if (press_age >= {16'd0, cfg.long_press_ms}) st_nxt = G_LONG;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Stamp updates and the event produced by this item.
  always_comb begin
    press_nxt   = press_r[sel];
    release_nxt = release_r[sel];
    ev_valid    = 1'b0;
    ev_kind     = EV_SINGLE;
    case (op)
      OP_PRESS: begin
        if (edge_ok) begin
          press_nxt = item.now_ms;
          if (st inside {G_IDLE, G_LONG}) release_nxt = '0;
          else if (!(st inside {G_PRESSED, G_SECOND, G_SHORT_REL})) release_nxt = '0;
        end
      end
      OP_RELEASE: begin
        if (edge_ok) begin
          if (st == G_PRESSED) begin
            release_nxt = item.now_ms;
          end else if (st == G_SECOND && press_age < {16'd0, cfg.long_press_ms}) begin
            ev_valid = 1'b1;
            ev_kind  = EV_DOUBLE;
          end
        end
      end
      OP_POLL: begin
        if (st == G_SHORT_REL && rel_age >= {16'd0, cfg.double_window_ms}) begin
          ev_valid = 1'b1;
          ev_kind  = EV_SINGLE;
        end else if ((st == G_PRESSED || st == G_SECOND) &&
                     press_age >= {16'd0, cfg.long_press_ms}) begin
          ev_valid = 1'b1;
          ev_kind  = EV_LONG;
        end
      end
      default: ;
    endcase
  end

  // Round-robin pointer wraps at the button count.
  assign ptr_nxt = (32'(ptr_r) == BUTTONS - 1) ? '0 : BTN_W'(32'(ptr_r) + 1);

  // Button state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUTTONS; i++) begin
        state_r[i]   <= G_IDLE;
        press_r[i]   <= '0;
        release_r[i] <= '0;
        last_r[i]    <= '0;
      end
      ptr_r <= '0;
    end else if (go) begin
      state_r[sel]   <= st_nxt;
      press_r[sel]   <= press_nxt;
      release_r[sel] <= release_nxt;
      if (edge_ok) last_r[sel] <= item.now_ms;
      if (op == OP_POLL) ptr_r <= ptr_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_ready) begin
      out_valid_r <= go && ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      out_button_r <= 2'(sel);
      out_kind_r   <= ev_kind;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_button = out_button_r;
  assign out_ch.event_kind   = out_kind_r;

endmodule

/* rtl/button_gesture_classifier_core.sv */
// Button gesture classifier. Each input beat is a press edge, a release edge or
// a poll tick with a 32-bit millisecond timestamp; a result beat reports a single,
// double or long press for one button. An item is registered on input and then
// classified combinationally against the per-button state, with the event
// landing in an output register, so one item is accepted every clock cycle while
// results drain. An accepted item passes the input register and then the result
// register before its result is on the output. A result that waits on the output
// holds the classification stage, and once the input register is also full the
// input is refused. Timing registers are written over the APB-style port:
// debounce at 0x0, long-press threshold at 0x4 and double-click window at 0x8,
// 16 bits each; write them only while idle.
module button_gesture_classifier_core (
  input  logic                        clk,
  input  logic                        rst_n,
  bgc_in_if.sink                      in_ch,
  bgc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgc_pkg::CFG_AW-1:0]  paddr,
  input  logic [bgc_pkg::CFG_DW-1:0]  pwdata,
  output logic [bgc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import bgc_pkg::*;

  cfg_t  cfg;
  logic  s1_valid_r;
  item_t s1_item_r;
  logic  eng_ready;
  logic  in_fire;

  bgc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register: refills in the same cycle that the engine takes its item.
  assign in_ch.ready = !s1_valid_r || eng_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.operation    <= in_ch.operation;
      s1_item_r.button_index <= in_ch.button_index;
      s1_item_r.now_ms       <= in_ch.now_ms;
    end
  end

  bgc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .item_ready (eng_ready),
    .out_ch     (out_ch)
  );

`ifndef NO_ASSERTIONS
  // An empty input register always takes a beat.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input refused while the input register is empty");

  // A held item stays put until the engine takes it.
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !eng_ready |=> s1_valid_r && $stable(s1_item_r))
    else $error("held item lost or changed while engine stalled");

  // Every event kind is a defined one.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.event_kind == EV_SINGLE || out_ch.event_kind == EV_DOUBLE ||
                      out_ch.event_kind == EV_LONG))
    else $error("undefined event kind on result beat");

  // A new result only follows an item that was held in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(s1_valid_r))
    else $error("result appeared without an item");
`endif

endmodule
